FILE: src/esa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esa_pkg;

    // default store geometry
    localparam int MAX_ENTITY_SLOTS_DEF = 1024;
    localparam int PROPERTY_SLOTS_DEF   = 16;

    // fixed field widths
    localparam int OP_W      = 3;
    localparam int ENT_IN_W  = 16;
    localparam int PROP_IN_W = 16;
    localparam int WORD_W    = 32;
    localparam int ENT_OUT_W = 10;
    localparam int CNT_OUT_W = 11;
    localparam int S_DATA_W  = 96;
    localparam int M_DATA_W  = 96;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC    = 3'd0,
        OP_FREE     = 3'd1,
        OP_GET      = 3'd2,
        OP_SET      = 3'd3,
        OP_COUNT    = 3'd4,
        OP_MARK     = 3'd5,
        OP_CHECKSUM = 3'd6
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic alloc_pop;
        logic alloc_fresh;
        logic reject;
        logic cnt_result;
        logic mark;
        logic cs_start;
        logic alloc_commit;
        logic free_commit;
        logic get_commit;
        logic set_commit;
        logic create;
        logic row_step;
        logic cs_acc;
        logic cs_next;
        logic cs_fin;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic ent_ok;
        logic prop_ok;
        logic stack_empty;
        logic fresh_avail;
        logic valid;
        logic auto_on;
        logic pidx_last;
        logic id_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: src/esa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module esa_datapath #(
    parameter int MAX_ENTITY_SLOTS = esa_pkg::MAX_ENTITY_SLOTS_DEF,
    parameter int PROPERTY_SLOTS   = esa_pkg::PROPERTY_SLOTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [esa_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic [esa_pkg::OP_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [esa_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tuser,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data,
    input  wire esa_pkg::cmd_t                 cmd,
    output esa_pkg::sts_t                      sts
);
    import esa_pkg::*;

    localparam int IDW   = $clog2(MAX_ENTITY_SLOTS);
    localparam int CNTW  = $clog2(MAX_ENTITY_SLOTS + 1);
    localparam int PIW   = (PROPERTY_SLOTS > 1) ? $clog2(PROPERTY_SLOTS) : 1;
    localparam int DEPTH = MAX_ENTITY_SLOTS * PROPERTY_SLOTS;
    localparam int AW    = $clog2(DEPTH);

    // memories
    logic              valid_mem [MAX_ENTITY_SLOTS];
    logic [WORD_W-1:0] prop_mem  [DEPTH];
    logic [IDW-1:0]    stack_mem [MAX_ENTITY_SLOTS];

    // request
    op_t               op_reg;
    logic              ent_ok_reg;
    logic              prop_ok_reg;
    logic [WORD_W-1:0] wval_reg;
    logic [WORD_W-1:0] frame_in_reg;
    logic [PIW-1:0]    preq_reg;

    // walk pointers and store state
    logic [IDW-1:0]    id_reg;
    logic [PIW-1:0]    pidx_reg;
    logic [CNTW-1:0]   stack_cnt_reg;
    logic [CNTW-1:0]   fresh_reg;
    logic [CNTW-1:0]   vcount_reg;
    logic [WORD_W-1:0] frame_reg;
    logic              auto_reg;
    logic [WORD_W-1:0] sum_reg;

    // memory read data
    logic              valid_q_reg;
    logic [WORD_W-1:0] prop_q_reg;
    logic [IDW-1:0]    stack_q_reg;

    // result under construction
    logic                 res_status_reg;
    logic [ENT_OUT_W-1:0] res_alloc_reg;
    logic [WORD_W-1:0]    res_rd_reg;
    logic [CNT_OUT_W-1:0] res_cnt_reg;
    logic [WORD_W-1:0]    res_csum_reg;
    logic                 res_dirty_reg;
    logic [ENT_OUT_W-1:0] res_dent_reg;

    // output stage
    logic                 out_valid_reg;
    logic                 out_user_reg;
    logic [M_DATA_W-1:0]  out_data_reg;

    logic [AW-1:0]     paddr;
    logic              v_we;
    logic              v_wd;
    logic              p_we;
    logic [WORD_W-1:0] p_wd;
    logic              word_differs;
    logic [WORD_W-1:0] cs_mix;
    logic [WORD_W-1:0] cs_rot;

    assign paddr        = AW'(id_reg) * AW'(PROPERTY_SLOTS) + AW'(pidx_reg);
    assign word_differs = (prop_q_reg != wval_reg);

    assign v_we = cmd.clr_step | cmd.alloc_commit | cmd.free_commit | cmd.create;
    assign v_wd = cmd.alloc_commit | cmd.create;

    // row clear writes zero, except the target word of an auto-created set
    assign p_we = cmd.row_step | (cmd.set_commit & word_differs);
    always_comb begin
        if (cmd.row_step) begin
            p_wd = ((op_reg == OP_SET) && (pidx_reg == preq_reg)) ? wval_reg : '0;
        end else begin
            p_wd = wval_reg;
        end
    end

    // checksum step: xor word, rotate left, fold in id after last word
    assign cs_mix = sum_reg ^ prop_q_reg;
    always_comb begin
        cs_rot = {cs_mix[WORD_W-2:0], cs_mix[WORD_W-1]};
        if (pidx_reg == PIW'(PROPERTY_SLOTS - 1)) begin
            cs_rot = cs_rot ^ WORD_W'(id_reg);
        end
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (v_we) begin
            valid_mem[id_reg] <= v_wd;
        end
        valid_q_reg <= valid_mem[id_reg];
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            prop_mem[paddr] <= p_wd;
        end
        prop_q_reg <= prop_mem[paddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.free_commit && (stack_cnt_reg != CNTW'(MAX_ENTITY_SLOTS))) begin
            stack_mem[IDW'(stack_cnt_reg)] <= id_reg;
        end
        stack_q_reg <= stack_mem[IDW'(stack_cnt_reg - CNTW'(1))];
    end

    // control state of the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_reg        <= '0;
            stack_cnt_reg <= '0;
            fresh_reg     <= '0;
            vcount_reg    <= '0;
            frame_reg     <= '0;
            auto_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                auto_reg <= cfg_wr_data;
            end
            if (cmd.mark) begin
                frame_reg <= frame_in_reg;
            end
            if (cmd.clr_step || cmd.cs_next) begin
                id_reg <= id_reg + IDW'(1);
            end else if (cmd.accept) begin
                id_reg <= IDW'(s_tdata[ENT_IN_W-1:0]);
            end else if (cmd.alloc_pop) begin
                id_reg <= stack_q_reg;
            end else if (cmd.alloc_fresh) begin
                id_reg <= IDW'(fresh_reg);
            end else if (cmd.cs_start) begin
                id_reg <= '0;
            end
            if (cmd.alloc_pop) begin
                stack_cnt_reg <= stack_cnt_reg - CNTW'(1);
            end else if (cmd.free_commit && (stack_cnt_reg != CNTW'(MAX_ENTITY_SLOTS))) begin
                stack_cnt_reg <= stack_cnt_reg + CNTW'(1);
            end
            if (cmd.alloc_fresh) begin
                fresh_reg <= fresh_reg + CNTW'(1);
            end else if (cmd.create && (CNTW'(id_reg) >= fresh_reg)) begin
                fresh_reg <= CNTW'(id_reg) + CNTW'(1);
            end
            if ((cmd.alloc_commit && !valid_q_reg) || cmd.create) begin
                vcount_reg <= vcount_reg + CNTW'(1);
            end else if (cmd.free_commit) begin
                vcount_reg <= vcount_reg - CNTW'(1);
            end
        end
    end

    // request capture, word index, checksum and result fields
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg       <= op_t'(s_tuser);
            ent_ok_reg   <= (17'(s_tdata[ENT_IN_W-1:0]) < 17'(MAX_ENTITY_SLOTS));
            prop_ok_reg  <= (17'(s_tdata[ENT_IN_W +: PROP_IN_W]) < 17'(PROPERTY_SLOTS));
            preq_reg     <= PIW'(s_tdata[ENT_IN_W +: PROP_IN_W]);
            wval_reg     <= s_tdata[32 +: WORD_W];
            frame_in_reg <= s_tdata[64 +: WORD_W];
        end
        if (cmd.accept) begin
            pidx_reg <= PIW'(s_tdata[ENT_IN_W +: PROP_IN_W]);
        end else if (cmd.alloc_commit || cmd.create || cmd.cs_start || cmd.cs_next) begin
            pidx_reg <= '0;
        end else if (cmd.row_step || cmd.cs_acc) begin
            pidx_reg <= pidx_reg + PIW'(1);
        end
        if (cmd.cs_start) begin
            sum_reg <= '0;
        end else if (cmd.cs_acc) begin
            sum_reg <= cs_rot;
        end
        if (cmd.accept) begin
            res_status_reg <= 1'b0;
            res_alloc_reg  <= '0;
            res_rd_reg     <= '0;
            res_cnt_reg    <= '0;
            res_csum_reg   <= '0;
            res_dirty_reg  <= 1'b0;
            res_dent_reg   <= '0;
        end else begin
            if (cmd.reject) begin
                res_status_reg <= 1'b1;
            end
            if (cmd.cnt_result) begin
                res_cnt_reg <= CNT_OUT_W'(vcount_reg);
            end
            if (cmd.get_commit) begin
                res_rd_reg <= prop_q_reg;
            end
            if (cmd.cs_fin) begin
                res_csum_reg <= sum_reg ^ frame_reg;
            end
            if (cmd.alloc_commit) begin
                res_alloc_reg <= ENT_OUT_W'(id_reg);
            end
            if (cmd.alloc_commit || cmd.free_commit ||
                (cmd.set_commit && word_differs) ||
                (cmd.create && (wval_reg != '0))) begin
                res_dirty_reg <= 1'b1;
                res_dent_reg  <= ENT_OUT_W'(id_reg);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_user_reg <= res_status_reg;
            out_data_reg <= {res_dent_reg, res_dirty_reg, res_csum_reg,
                             res_cnt_reg, res_rd_reg, res_alloc_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // status to controller
    assign sts.op          = op_reg;
    assign sts.ent_ok      = ent_ok_reg;
    assign sts.prop_ok     = prop_ok_reg;
    assign sts.stack_empty = (stack_cnt_reg == '0);
    assign sts.fresh_avail = (fresh_reg < CNTW'(MAX_ENTITY_SLOTS));
    assign sts.valid       = valid_q_reg;
    assign sts.auto_on     = auto_reg;
    assign sts.pidx_last   = (pidx_reg == PIW'(PROPERTY_SLOTS - 1));
    assign sts.id_last     = (id_reg == IDW'(MAX_ENTITY_SLOTS - 1));
    assign sts.out_free    = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

FILE: src/esa_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module esa_controller (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire esa_pkg::sts_t sts,
    output esa_pkg::cmd_t      cmd
);
    import esa_pkg::*;

    typedef enum logic [11:0] {
        ST_CLEAR   = 12'b000000000001,
        ST_IDLE    = 12'b000000000010,
        ST_DECODE  = 12'b000000000100,
        ST_VWAIT   = 12'b000000001000,
        ST_ACT     = 12'b000000010000,
        ST_ROWCLR  = 12'b000000100000,
        ST_CS_WAIT = 12'b000001000000,
        ST_CS_V    = 12'b000010000000,
        ST_CS_RD   = 12'b000100000000,
        ST_CS_ACC  = 12'b001000000000,
        ST_CS_FIN  = 12'b010000000000,
        ST_DONE    = 12'b100000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // sequencing of each request
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.id_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_DONE;
                case (sts.op)
                    OP_ALLOC: begin
                        if (!sts.stack_empty) begin
                            cmd.alloc_pop = 1'b1;
                            state_next    = ST_VWAIT;
                        end else if (sts.fresh_avail) begin
                            cmd.alloc_fresh = 1'b1;
                            state_next      = ST_VWAIT;
                        end else begin
                            cmd.reject = 1'b1;
                        end
                    end
                    OP_FREE: begin
                        if (sts.ent_ok) begin
                            state_next = ST_VWAIT;
                        end else begin
                            cmd.reject = 1'b1;
                        end
                    end
                    OP_GET, OP_SET: begin
                        if (sts.ent_ok && sts.prop_ok) begin
                            state_next = ST_VWAIT;
                        end else begin
                            cmd.reject = 1'b1;
                        end
                    end
                    OP_COUNT: cmd.cnt_result = 1'b1;
                    OP_MARK:  cmd.mark = 1'b1;
                    OP_CHECKSUM: begin
                        cmd.cs_start = 1'b1;
                        state_next   = ST_CS_WAIT;
                    end
                    default: cmd.reject = 1'b1;
                endcase
            end
            ST_VWAIT: state_next = ST_ACT;
            ST_ACT: begin
                state_next = ST_DONE;
                case (sts.op)
                    OP_ALLOC: begin
                        cmd.alloc_commit = 1'b1;
                        state_next       = ST_ROWCLR;
                    end
                    OP_FREE: begin
                        cmd.free_commit = sts.valid;
                        cmd.reject      = !sts.valid;
                    end
                    OP_GET: begin
                        cmd.get_commit = sts.valid;
                        cmd.reject     = !sts.valid;
                    end
                    OP_SET: begin
                        if (sts.valid) begin
                            cmd.set_commit = 1'b1;
                        end else if (sts.auto_on) begin
                            cmd.create = 1'b1;
                            state_next = ST_ROWCLR;
                        end else begin
                            cmd.reject = 1'b1;
                        end
                    end
                    default: cmd.reject = 1'b0;
                endcase
            end
            ST_ROWCLR: begin
                cmd.row_step = 1'b1;
                if (sts.pidx_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_CS_WAIT: state_next = ST_CS_V;
            ST_CS_V: begin
                if (sts.valid) begin
                    state_next = ST_CS_ACC;
                end else if (sts.id_last) begin
                    state_next = ST_CS_FIN;
                end else begin
                    cmd.cs_next = 1'b1;
                    state_next  = ST_CS_WAIT;
                end
            end
            ST_CS_RD: state_next = ST_CS_ACC;
            ST_CS_ACC: begin
                cmd.cs_acc = 1'b1;
                if (!sts.pidx_last) begin
                    state_next = ST_CS_RD;
                end else if (sts.id_last) begin
                    state_next = ST_CS_FIN;
                end else begin
                    state_next = ST_CS_V;
                    cmd.cs_next = 1'b1;
                    state_next  = ST_CS_WAIT;
                end
            end
            ST_CS_FIN: begin
                cmd.cs_fin = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/entity_slot_allocator_property_store_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Entity slot store: each entity has a valid bit and a row of signed property
// words. Requests carry an opcode on s_tuser (allocate, free, get, set, count,
// mark frame, checksum) and give one result each. After reset the block clears
// the valid bit of every entity slot in turn before it takes a request.
// One request is worked at a time through memories with registered reads.
// Allocate and an auto-creating set also clear the row, one word per cycle.
// Checksum spends a wait state and a check state on every valid bit and reads
// each word of a valid row through a read state and an accumulate state.
// A finished result waits in the output register while the next request runs.
module entity_slot_allocator_property_store_unit #(
    parameter int MAX_ENTITY_SLOTS = esa_pkg::MAX_ENTITY_SLOTS_DEF,
    parameter int PROPERTY_SLOTS   = esa_pkg::PROPERTY_SLOTS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // entity[15:0], property_req[31:16], write_value[63:32], frame_number[95:64]
    input  wire logic [esa_pkg::S_DATA_W-1:0] s_tdata,
    // opcode[2:0]
    input  wire logic [esa_pkg::OP_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // allocated_entity[9:0], read_value[41:10], valid_count[52:42],
    // checksum[84:53], dirty[85], dirty_entity[95:86]
    output logic [esa_pkg::M_DATA_W-1:0]      m_tdata,
    // status[0]
    output logic                              m_tuser,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_wr_data
);
    import esa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    esa_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    esa_datapath #(
        .MAX_ENTITY_SLOTS (MAX_ENTITY_SLOTS),
        .PROPERTY_SLOTS   (PROPERTY_SLOTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

FILE: tb/entity_slot_store_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps a copy of the store and
// compares every result with the oldest predicted one.
module entity_slot_store_checker
    import esa_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [OP_W-1:0]     s_tuser,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [M_DATA_W-1:0] m_tdata,
    input  wire logic                m_tuser,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    output int                       errors,
    output int                       pending
);

    localparam int SLOTS = MAX_ENTITY_SLOTS_DEF;
    localparam int PROPS = PROPERTY_SLOTS_DEF;

    typedef struct {
        logic                 status;
        logic [ENT_OUT_W-1:0] alloc_id;
        logic [WORD_W-1:0]    rd_word;
        logic [CNT_OUT_W-1:0] live_cnt;
        logic [WORD_W-1:0]    fold;
        logic                 dirty;
        logic [ENT_OUT_W-1:0] dirty_id;
    } store_reply_t;

    // shadow of the store
    logic                 live [SLOTS];
    logic [WORD_W-1:0]    words [SLOTS*PROPS];
    logic [ENT_OUT_W-1:0] free_ids [SLOTS];
    int                   free_top;
    int                   fresh_id;
    logic [WORD_W-1:0]    frame_mark;
    logic                 auto_create;

    store_reply_t replies_due [$];

    task automatic wipe_row(input int id);
        for (int p = 0; p < PROPS; p++) words[id*PROPS + p] = '0;
    endtask

    // apply one request to the shadow store and return its reply
    task automatic run_request(input logic [OP_W-1:0] code, input logic [S_DATA_W-1:0] d,
                               output store_reply_t r);
        int ent;
        int prop;
        int id;
        logic [WORD_W-1:0] wval;
        bit ent_ok;
        bit prop_ok;
        ent  = int'(d[15:0]);
        prop = int'(d[31:16]);
        wval = d[63:32];
        ent_ok  = ent < SLOTS;
        prop_ok = prop < PROPS;
        r = '{default: '0};
        case (code)
            OP_ALLOC: begin
                if (free_top > 0) begin
                    free_top--;
                    id = int'(free_ids[free_top]);
                end else if (fresh_id < SLOTS) begin
                    id = fresh_id;
                    fresh_id++;
                end else begin
                    r.status = 1'b1;
                    return;
                end
                live[id] = 1'b1;
                wipe_row(id);
                r.alloc_id = ENT_OUT_W'(id);
                r.dirty    = 1'b1;
                r.dirty_id = ENT_OUT_W'(id);
            end
            OP_FREE: begin
                if (!ent_ok || !live[ent]) begin
                    r.status = 1'b1;
                    return;
                end
                live[ent] = 1'b0;
                // a full stack drops the id
                if (free_top < SLOTS) begin
                    free_ids[free_top] = ENT_OUT_W'(ent);
                    free_top++;
                end
                r.dirty    = 1'b1;
                r.dirty_id = ENT_OUT_W'(ent);
            end
            OP_GET: begin
                if (!ent_ok || !prop_ok || !live[ent]) r.status = 1'b1;
                else r.rd_word = words[ent*PROPS + prop];
            end
            OP_SET: begin
                if (!ent_ok || !prop_ok) begin
                    r.status = 1'b1;
                    return;
                end
                if (auto_create && !live[ent]) begin
                    live[ent] = 1'b1;
                    if (ent >= fresh_id) fresh_id = ent + 1;
                    wipe_row(ent);
                end
                if (!live[ent]) begin
                    r.status = 1'b1;
                    return;
                end
                if (words[ent*PROPS + prop] != wval) begin
                    words[ent*PROPS + prop] = wval;
                    r.dirty    = 1'b1;
                    r.dirty_id = ENT_OUT_W'(ent);
                end
            end
            OP_COUNT: begin
                for (int i = 0; i < SLOTS; i++) r.live_cnt += CNT_OUT_W'(live[i]);
            end
            OP_MARK: frame_mark = d[95:64];
            OP_CHECKSUM: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (live[i]) begin
                        for (int p = 0; p < PROPS; p++) begin
                            r.fold ^= words[i*PROPS + p];
                            r.fold = {r.fold[WORD_W-2:0], r.fold[WORD_W-1]};
                        end
                        r.fold ^= WORD_W'(i);
                    end
                end
                r.fold ^= frame_mark;
            end
            default: r.status = 1'b1;
        endcase
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        store_reply_t r;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                live[i]     = 1'b0;
                free_ids[i] = '0;
            end
            for (int i = 0; i < SLOTS*PROPS; i++) words[i] = '0;
            free_top    = 0;
            fresh_id    = 0;
            frame_mark  = '0;
            auto_create = 1'b0;
            replies_due.delete();
        end else begin
            if (cfg_wr_en) auto_create = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                run_request(s_tuser, s_tdata, r);
                replies_due.push_back(r);
            end
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: result with none expected, actual %h/%b",
                             $realtime, m_tdata, m_tuser);
                    errors++;
                end else begin
                    r = replies_due.pop_front();
                    check_field("status", WORD_W'(r.status), WORD_W'(m_tuser));
                    check_field("allocated_entity", WORD_W'(r.alloc_id),
                                WORD_W'(m_tdata[9:0]));
                    check_field("read_value", r.rd_word, m_tdata[41:10]);
                    check_field("valid_count", WORD_W'(r.live_cnt), WORD_W'(m_tdata[52:42]));
                    check_field("checksum", r.fold, m_tdata[84:53]);
                    check_field("dirty", WORD_W'(r.dirty), WORD_W'(m_tdata[85]));
                    check_field("dirty_entity", WORD_W'(r.dirty_id), WORD_W'(m_tdata[95:86]));
                end
            end
        end
        pending = replies_due.size();
    end

    initial begin
        errors  = 0;
        pending = 0;
    end

endmodule

FILE: tb/entity_slot_allocator_property_store_unit_test.sv
`timescale 1ns / 1ps

module entity_slot_allocator_property_store_unit_test;
    import esa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 200000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]     s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_wr_data = 1'b0;
    int                  errors;
    int                  pending;
    bit                  quiet = 1'b0;
    int                  op_sent [8];
    int                  idle_cycles = 0;

    entity_slot_allocator_property_store_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    entity_slot_store_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .errors(errors), .pending(pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver stalls in bursts
    always @(posedge aclk) begin
        int hold;
        if (quiet || !aresetn) begin
            m_tready <= 1'b1;
        end else if (hold > 0) begin
            hold--;
        end else begin
            m_tready <= ($urandom_range(0, 2) != 0);
            hold = $urandom_range(1, 8);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("entity_slot_allocator_property_store_unit_test NOT OK");
            $finish;
        end
    end

    task automatic send(input logic [OP_W-1:0] code, input logic [15:0] ent,
                        input logic [15:0] prop, input logic [31:0] wval,
                        input logic [31:0] frame);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= {frame, wval, prop, ent};
        op_sent[code]++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the sender until every result is back, then write the register
    task automatic settle_and_config(input logic auto_on);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= auto_on;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_request();
        logic [OP_W-1:0] code;
        logic [15:0] ent;
        logic [15:0] prop;
        logic [31:0] wval;
        int pick;
        pick = $urandom_range(0, 199);
        if (pick < 40) code = OP_ALLOC;
        else if (pick < 70) code = OP_FREE;
        else if (pick < 110) code = OP_GET;
        else if (pick < 170) code = OP_SET;
        else if (pick < 182) code = OP_COUNT;
        else if (pick < 193) code = OP_MARK;
        else if (pick < 196) code = OP_CHECKSUM;
        else code = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 85) ent = 16'($urandom_range(0, 31));
        else if (pick < 95) ent = 16'($urandom_range(0, 1023));
        else if (pick < 98) ent = 16'($urandom_range(1024, 65535));
        else ent = 16'($urandom);
        prop = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) wval = $urandom;
        else if (pick < 85) wval = $urandom_range(0, 3);
        else wval = pick[0] ? 32'h8000_0000 : 32'h7fff_ffff;
        send(code, ent, prop, wval, $urandom);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        settle_and_config(1'b0);

        // directed: rejects, unchanged set, stack reuse, row clear, opcode gap
        send(OP_ALLOC, 0, 0, 0, 0);
        send(OP_ALLOC, 0, 0, 0, 0);
        send(OP_ALLOC, 0, 0, 0, 0);
        send(OP_SET, 1, 3, 32'h7fff_ffff, 0);
        send(OP_SET, 1, 3, 32'h7fff_ffff, 0);
        send(OP_GET, 1, 3, 0, 0);
        send(OP_GET, 1, 15, 0, 0);
        send(OP_GET, 1, 16, 0, 0);
        send(OP_GET, 5, 0, 0, 0);
        send(OP_SET, 5, 0, 32'h1234_5678, 0);
        send(OP_SET, 1, 16'hffff, 32'h1, 0);
        send(OP_FREE, 1, 0, 0, 0);
        send(OP_FREE, 1, 0, 0, 0);
        send(OP_FREE, 16'hffff, 0, 0, 0);
        send(OP_ALLOC, 0, 0, 0, 0);
        send(OP_GET, 1, 3, 0, 0);
        send(OP_COUNT, 0, 0, 0, 0);
        send(OP_MARK, 0, 0, 0, 32'h8000_0000);
        send(OP_CHECKSUM, 0, 0, 0, 0);
        send(OP_UNUSED, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
        settle_and_config(1'b1);
        // auto-create, then fresh ids exhausted by the top slot
        send(OP_SET, 900, 15, 32'h8000_0000, 0);
        send(OP_SET, 1023, 0, 32'hffff_ffff, 0);
        send(OP_ALLOC, 0, 0, 0, 0);
        send(OP_SET, 16'hffff, 0, 32'h5, 0);
        send(OP_CHECKSUM, 0, 0, 0, 0);

        // random phases, register toggled between them
        for (int ph = 0; ph < 5; ph++) begin
            settle_and_config(ph[0]);
            for (int n = 0; n < 250; n++) begin
                if (ph == 4 && n >= 100) quiet = 1'b1;
                random_request();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d alloc, %0d free, %0d get, %0d set, %0d count, %0d mark,",
                 op_sent[OP_ALLOC], op_sent[OP_FREE], op_sent[OP_GET], op_sent[OP_SET],
                 op_sent[OP_COUNT], op_sent[OP_MARK]);
        $display("%0d checksum and %0d unused-opcode requests, auto-create off and on",
                 op_sent[OP_CHECKSUM], op_sent[OP_UNUSED]);
        if (errors == 0) begin
            $display("entity_slot_allocator_property_store_unit_test OK");
        end else begin
            $display("entity_slot_allocator_property_store_unit_test NOT OK");
        end
        $finish;
    end

endmodule
